>>> rtl/core/c2p_pkg.sv
// Shared constants, the control bundle type and the arctangent table of the polar converter.
package c2p_pkg;

   localparam int ITERATIONS_DEF  = 16;
   localparam int INPUT_WIDTH_DEF = 16;

   localparam int ATAN_ENTRIES  = 24;
   localparam int Z_WIDTH       = 24;
   localparam int XY_SCALE_BITS = 24;
   localparam int ROUND_BITS    = 7;
   localparam int MAG_WIDTH     = 16;
   localparam int ANGLE_WIDTH   = 16;
   localparam int ANGLE_LIMIT   = 25736;
   localparam int PI20          = 3294199;
   localparam int MAG_MAX       = 65535;

   localparam logic signed [Z_WIDTH-1:0] PI_Z = Z_WIDTH'(PI20);

   typedef struct packed {
      logic valid;
      logic end_of_block;
      logic was_zero;
   } c2p_ctrl_type;

   // round(atan(2^-idx) * 2^20)
   function automatic logic signed [Z_WIDTH-1:0] atan_entry(input int unsigned idx);
      case (idx)
         0:       return Z_WIDTH'(823550);
         1:       return Z_WIDTH'(486170);
         2:       return Z_WIDTH'(256879);
         3:       return Z_WIDTH'(130396);
         4:       return Z_WIDTH'(65451);
         5:       return Z_WIDTH'(32757);
         6:       return Z_WIDTH'(16383);
         7:       return Z_WIDTH'(8192);
         8:       return Z_WIDTH'(4096);
         9:       return Z_WIDTH'(2048);
         10:      return Z_WIDTH'(1024);
         11:      return Z_WIDTH'(512);
         12:      return Z_WIDTH'(256);
         13:      return Z_WIDTH'(128);
         14:      return Z_WIDTH'(64);
         15:      return Z_WIDTH'(32);
         16:      return Z_WIDTH'(16);
         17:      return Z_WIDTH'(8);
         18:      return Z_WIDTH'(4);
         19:      return Z_WIDTH'(2);
         20:      return Z_WIDTH'(1);
         default: return '0;
      endcase
   endfunction

endpackage

>>> rtl/core/cartesian_to_polar_default_angle_top.sv
// Top level of the pipelined cartesian to polar converter with a default angle for zero.
//
//   channel  direction  handshake             beat
//   req      in         req_valid/req_stall   real_part, imag_part, end_of_block
//   rsp      out        rsp_valid/rsp_stall   magnitude, angle, was_zero, end_of_block_out
//   csr      in         csr_valid/csr_ready   default_angle
//
// One beat enters per cycle unless the output stalls; depth follows the longer of
// the square root chain (one digit per stage) and CORDIC chain (one rotation per stage).
// Reset is synchronous and clears the stage valid bits and default_angle.
// A stalled output beat holds the whole pipeline in place; req_stall rises with it.
// csr_ready is always high; write default_angle only while the pipeline is empty.
module cartesian_to_polar_default_angle_top #(
   parameter int ITERATIONS  = c2p_pkg::ITERATIONS_DEF,
   parameter int INPUT_WIDTH = c2p_pkg::INPUT_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [INPUT_WIDTH-1:0]          req_real_part,
   input  logic signed [INPUT_WIDTH-1:0]          req_imag_part,
   input  logic                                   req_end_of_block,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [c2p_pkg::MAG_WIDTH-1:0]          rsp_magnitude,
   output logic signed [c2p_pkg::ANGLE_WIDTH-1:0] rsp_angle,
   output logic                                   rsp_was_zero,
   output logic                                   rsp_end_of_block_out,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic signed [c2p_pkg::ANGLE_WIDTH-1:0] csr_default_angle
);

   localparam int W     = INPUT_WIDTH;
   localparam int XYW   = INPUT_WIDTH + c2p_pkg::XY_SCALE_BITS + 2;
   localparam int NSTEP = (ITERATIONS > INPUT_WIDTH) ? ITERATIONS : INPUT_WIDTH;
   localparam logic signed [c2p_pkg::ANGLE_WIDTH-1:0] ALIM =
      c2p_pkg::ANGLE_WIDTH'(c2p_pkg::ANGLE_LIMIT);

   logic adv;
   logic signed [c2p_pkg::ANGLE_WIDTH-1:0] default_angle_ff;

   c2p_pkg::c2p_ctrl_type ctrl_chain [NSTEP+1];
   logic [2*W-1:0]        s_chain    [NSTEP+1];
   logic [W-1:0]          q_chain    [NSTEP+1];
   logic [W:0]            rem_chain  [NSTEP+1];
   logic signed [XYW-1:0] x_chain    [NSTEP+1];
   logic signed [XYW-1:0] y_chain    [NSTEP+1];
   logic signed [c2p_pkg::Z_WIDTH-1:0] z_chain [NSTEP+1];

   // advance everything unless the output beat is waiting on a stall
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         default_angle_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         default_angle_ff <= csr_default_angle;
      end
   end

   c2p_front #(.INPUT_WIDTH(INPUT_WIDTH)) u_front (
      .clock            (clock),
      .reset            (reset),
      .adv              (adv),
      .req_valid        (req_valid),
      .req_real_part    (req_real_part),
      .req_imag_part    (req_imag_part),
      .req_end_of_block (req_end_of_block),
      .dn_ctrl          (ctrl_chain[0]),
      .dn_s             (s_chain[0]),
      .dn_x             (x_chain[0]),
      .dn_y             (y_chain[0]),
      .dn_z             (z_chain[0])
   );

   // square root starts with empty root and remainder
   assign q_chain[0]   = '0;
   assign rem_chain[0] = '0;

   for (genvar k = 0; k < NSTEP; k++) begin : g_stage
      c2p_stage #(
         .INPUT_WIDTH (INPUT_WIDTH),
         .K           (k),
         .DO_SQRT     (k < INPUT_WIDTH),
         .DO_CORDIC   (k < ITERATIONS)
      ) u_stage (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .up_ctrl (ctrl_chain[k]),
         .up_s    (s_chain[k]),
         .up_q    (q_chain[k]),
         .up_rem  (rem_chain[k]),
         .up_x    (x_chain[k]),
         .up_y    (y_chain[k]),
         .up_z    (z_chain[k]),
         .dn_ctrl (ctrl_chain[k+1]),
         .dn_s    (s_chain[k+1]),
         .dn_q    (q_chain[k+1]),
         .dn_rem  (rem_chain[k+1]),
         .dn_x    (x_chain[k+1]),
         .dn_y    (y_chain[k+1]),
         .dn_z    (z_chain[k+1])
      );
   end

   c2p_back #(.INPUT_WIDTH(INPUT_WIDTH)) u_back (
      .clock                (clock),
      .reset                (reset),
      .adv                  (adv),
      .up_ctrl              (ctrl_chain[NSTEP]),
      .up_q                 (q_chain[NSTEP]),
      .up_rem               (rem_chain[NSTEP]),
      .up_z                 (z_chain[NSTEP]),
      .default_angle        (default_angle_ff),
      .rsp_valid            (rsp_valid),
      .rsp_magnitude        (rsp_magnitude),
      .rsp_angle            (rsp_angle),
      .rsp_was_zero         (rsp_was_zero),
      .rsp_end_of_block_out (rsp_end_of_block_out)
   );

   // zero sample always reports a zero norm
   a_zero_mag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_was_zero |-> rsp_magnitude == '0)
      else $error("zero sample with nonzero magnitude");

   // any nonzero sample has a norm of at least one
   a_nonzero_mag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_was_zero |-> rsp_magnitude != '0)
      else $error("nonzero sample with zero magnitude");

   // computed angles stay inside the clamp range
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_was_zero |-> (rsp_angle <= ALIM) && (rsp_angle >= -ALIM))
      else $error("angle outside clamp range");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid right after reset");

endmodule

>>> rtl/core/c2p_front.sv
// Input register, squaring and prerotation stage, and the sum of squares stage.
module c2p_front #(
   parameter int INPUT_WIDTH = c2p_pkg::INPUT_WIDTH_DEF,
   localparam int XYW = INPUT_WIDTH + c2p_pkg::XY_SCALE_BITS + 2
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               adv,
   input  logic                               req_valid,
   input  logic signed [INPUT_WIDTH-1:0]      req_real_part,
   input  logic signed [INPUT_WIDTH-1:0]      req_imag_part,
   input  logic                               req_end_of_block,
   output c2p_pkg::c2p_ctrl_type              dn_ctrl,
   output logic [2*INPUT_WIDTH-1:0]           dn_s,
   output logic signed [XYW-1:0]              dn_x,
   output logic signed [XYW-1:0]              dn_y,
   output logic signed [c2p_pkg::Z_WIDTH-1:0] dn_z
);

   localparam int W  = INPUT_WIDTH;
   localparam int SB = c2p_pkg::XY_SCALE_BITS;

   c2p_pkg::c2p_ctrl_type ctrl1_in, ctrl1_ff, ctrl2_ff, ctrl3_ff;

   logic signed [W-1:0] re_ff, im_ff;

   logic [W-1:0]   ar, ai;
   logic [2*W-1:0] sq_re_in, sq_im_ff, sq_im_in, sq_re_ff;
   logic [2*W-1:0] s_in, s_ff;

   logic signed [XYW-1:0] x_pre, y_pre;
   logic signed [XYW-1:0] x2_in, y2_in, x2_ff, y2_ff, x3_ff, y3_ff;
   logic signed [c2p_pkg::Z_WIDTH-1:0] z2_in, z2_ff, z3_ff;

   assign ctrl1_in = '{valid:        req_valid,
                       end_of_block: req_end_of_block,
                       was_zero:     (req_real_part == '0) && (req_imag_part == '0)};

   always_comb begin
      ar = re_ff[W-1] ? W'(-re_ff) : W'(re_ff);
      ai = im_ff[W-1] ? W'(-im_ff) : W'(im_ff);
      sq_re_in = ar * ar;
      sq_im_in = ai * ai;
      x_pre = {{(XYW-W-SB){re_ff[W-1]}}, re_ff, {SB{1'b0}}};
      y_pre = {{(XYW-W-SB){im_ff[W-1]}}, im_ff, {SB{1'b0}}};
      // fold the left half plane over, start the angle at +/- pi
      if (re_ff[W-1]) begin
         x2_in = -x_pre;
         y2_in = -y_pre;
         z2_in = im_ff[W-1] ? -c2p_pkg::PI_Z : c2p_pkg::PI_Z;
      end else begin
         x2_in = x_pre;
         y2_in = y_pre;
         z2_in = '0;
      end
   end

   assign s_in = sq_re_ff + sq_im_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl1_ff <= '0;
         ctrl2_ff <= '0;
         ctrl3_ff <= '0;
      end else if (adv) begin
         ctrl1_ff <= ctrl1_in;
         ctrl2_ff <= ctrl1_ff;
         ctrl3_ff <= ctrl2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         re_ff    <= req_real_part;
         im_ff    <= req_imag_part;
         sq_re_ff <= sq_re_in;
         sq_im_ff <= sq_im_in;
         x2_ff    <= x2_in;
         y2_ff    <= y2_in;
         z2_ff    <= z2_in;
         s_ff     <= s_in;
         x3_ff    <= x2_ff;
         y3_ff    <= y2_ff;
         z3_ff    <= z2_ff;
      end
   end

   assign dn_ctrl = ctrl3_ff;
   assign dn_s    = s_ff;
   assign dn_x    = x3_ff;
   assign dn_y    = y3_ff;
   assign dn_z    = z3_ff;

endmodule

>>> rtl/core/c2p_stage.sv
// One pipeline stage: one square root digit if DO_SQRT, one CORDIC micro-rotation if DO_CORDIC.
module c2p_stage #(
   parameter int INPUT_WIDTH = c2p_pkg::INPUT_WIDTH_DEF,
   parameter int K           = 0,
   parameter bit DO_SQRT     = 1'b1,
   parameter bit DO_CORDIC   = 1'b1,
   localparam int XYW = INPUT_WIDTH + c2p_pkg::XY_SCALE_BITS + 2
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               adv,
   input  c2p_pkg::c2p_ctrl_type              up_ctrl,
   input  logic [2*INPUT_WIDTH-1:0]           up_s,
   input  logic [INPUT_WIDTH-1:0]             up_q,
   input  logic [INPUT_WIDTH:0]               up_rem,
   input  logic signed [XYW-1:0]              up_x,
   input  logic signed [XYW-1:0]              up_y,
   input  logic signed [c2p_pkg::Z_WIDTH-1:0] up_z,
   output c2p_pkg::c2p_ctrl_type              dn_ctrl,
   output logic [2*INPUT_WIDTH-1:0]           dn_s,
   output logic [INPUT_WIDTH-1:0]             dn_q,
   output logic [INPUT_WIDTH:0]               dn_rem,
   output logic signed [XYW-1:0]              dn_x,
   output logic signed [XYW-1:0]              dn_y,
   output logic signed [c2p_pkg::Z_WIDTH-1:0] dn_z
);

   localparam int W = INPUT_WIDTH;
   localparam logic signed [c2p_pkg::Z_WIDTH-1:0] ATAN_K = c2p_pkg::atan_entry(K);

   c2p_pkg::c2p_ctrl_type ctrl_ff;

   logic [W+2:0]   rem_cat, trial;
   logic [2*W-1:0] s_in, s_ff;
   logic [W-1:0]   q_in, q_ff;
   logic [W:0]     rem_in, rem_ff;

   logic signed [XYW-1:0] xs, ys, x_in, y_in, x_ff, y_ff;
   logic signed [c2p_pkg::Z_WIDTH-1:0] z_in, z_ff;

   // restoring square root: bring down two bits, try (4q + 1)
   always_comb begin
      rem_cat = {up_rem, up_s[2*W-1 -: 2]};
      trial   = {1'b0, up_q, 2'b01};
      if (DO_SQRT) begin
         s_in = up_s << 2;
         if (rem_cat >= trial) begin
            rem_in = (W+1)'(rem_cat - trial);
            q_in   = {up_q[W-2:0], 1'b1};
         end else begin
            rem_in = rem_cat[W:0];
            q_in   = {up_q[W-2:0], 1'b0};
         end
      end else begin
         s_in   = up_s;
         rem_in = up_rem;
         q_in   = up_q;
      end
   end

   // rotate toward the positive real axis
   always_comb begin
      xs = up_x >>> K;
      ys = up_y >>> K;
      if (!DO_CORDIC) begin
         x_in = up_x;
         y_in = up_y;
         z_in = up_z;
      end else if (!up_y[XYW-1]) begin
         x_in = up_x + ys;
         y_in = up_y - xs;
         z_in = up_z + ATAN_K;
      end else begin
         x_in = up_x - ys;
         y_in = up_y + xs;
         z_in = up_z - ATAN_K;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (adv) begin
         ctrl_ff <= up_ctrl;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s_ff   <= s_in;
         q_ff   <= q_in;
         rem_ff <= rem_in;
         x_ff   <= x_in;
         y_ff   <= y_in;
         z_ff   <= z_in;
      end
   end

   assign dn_ctrl = ctrl_ff;
   assign dn_s    = s_ff;
   assign dn_q    = q_ff;
   assign dn_rem  = rem_ff;
   assign dn_x    = x_ff;
   assign dn_y    = y_ff;
   assign dn_z    = z_ff;

endmodule

>>> rtl/core/c2p_back.sv
// Final stage: magnitude rounding and saturation, angle rounding and clamping, zero override.
module c2p_back #(
   parameter int INPUT_WIDTH = c2p_pkg::INPUT_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   adv,
   input  c2p_pkg::c2p_ctrl_type                  up_ctrl,
   input  logic [INPUT_WIDTH-1:0]                 up_q,
   input  logic [INPUT_WIDTH:0]                   up_rem,
   input  logic signed [c2p_pkg::Z_WIDTH-1:0]     up_z,
   input  logic signed [c2p_pkg::ANGLE_WIDTH-1:0] default_angle,
   output logic                                   rsp_valid,
   output logic [c2p_pkg::MAG_WIDTH-1:0]          rsp_magnitude,
   output logic signed [c2p_pkg::ANGLE_WIDTH-1:0] rsp_angle,
   output logic                                   rsp_was_zero,
   output logic                                   rsp_end_of_block_out
);

   localparam int W  = INPUT_WIDTH;
   localparam int ZW = c2p_pkg::Z_WIDTH;
   localparam int CW = (W + 1 > c2p_pkg::MAG_WIDTH + 1) ? W + 1 : c2p_pkg::MAG_WIDTH + 1;
   localparam logic signed [ZW-1:0] LIMIT_Z = ZW'(c2p_pkg::ANGLE_LIMIT);
   localparam logic signed [ZW-1:0] HALF_Z  = ZW'(1 << (c2p_pkg::ROUND_BITS - 1));

   logic [W:0]  r_round;
   logic [CW-1:0] r_wide;
   logic signed [ZW-1:0] z_round, a_full, a_clamp;

   logic                                   valid_ff;
   logic [c2p_pkg::MAG_WIDTH-1:0]          mag_in, mag_ff;
   logic signed [c2p_pkg::ANGLE_WIDTH-1:0] angle_in, angle_ff;
   logic                                   zero_ff, eob_ff;

   always_comb begin
      // remainder above the root means the true norm lies past the half point
      r_round = {1'b0, up_q} + (W+1)'(up_rem > {1'b0, up_q});
      r_wide  = CW'(r_round);
      z_round = up_z + HALF_Z;
      a_full  = z_round >>> c2p_pkg::ROUND_BITS;
      if (a_full > LIMIT_Z) begin
         a_clamp = LIMIT_Z;
      end else if (a_full < -LIMIT_Z) begin
         a_clamp = -LIMIT_Z;
      end else begin
         a_clamp = a_full;
      end
      if (up_ctrl.was_zero) begin
         mag_in   = '0;
         angle_in = default_angle;
      end else begin
         mag_in   = (r_wide > CW'(c2p_pkg::MAG_MAX)) ? c2p_pkg::MAG_WIDTH'(c2p_pkg::MAG_MAX)
                                                     : c2p_pkg::MAG_WIDTH'(r_wide);
         angle_in = c2p_pkg::ANGLE_WIDTH'(a_clamp);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= up_ctrl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mag_ff   <= mag_in;
         angle_ff <= angle_in;
         zero_ff  <= up_ctrl.was_zero;
         eob_ff   <= up_ctrl.end_of_block;
      end
   end

   assign rsp_valid            = valid_ff;
   assign rsp_magnitude        = mag_ff;
   assign rsp_angle            = angle_ff;
   assign rsp_was_zero         = zero_ff;
   assign rsp_end_of_block_out = eob_ff;

endmodule
